// File: rtl/core/trc_pkg.sv
// Package for the touch report calibrator: constants, sequencer states,
// register indexes and the request/response types of the shared divider.
// No dependencies.
`default_nettype none
package trc_pkg;

  localparam int unsigned REPORT_BYTES_DEF = 8;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NUM_W   = 2 * COORD_W;
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [COORD_W-1:0] X_ZERO_RST = 12'd627;
  localparam logic [COORD_W-1:0] X_FULL_RST = 12'd10;
  localparam logic [COORD_W-1:0] X_FS_RST   = 12'd640;
  localparam logic [COORD_W-1:0] Y_ZERO_RST = 12'd176;
  localparam logic [COORD_W-1:0] Y_FULL_RST = 12'd6;
  localparam logic [COORD_W-1:0] Y_FS_RST   = 12'd180;
  localparam logic [HOLD_W-1:0]  HOLD_RST   = 16'd250;
  localparam logic [HOLD_W-1:0]  ELAPSED_RST = 16'd250;
  localparam logic [3:0]         NIBBLE_MASK = 4'hF;

  typedef enum logic [IDX_W-1:0] {
    REG_X_ZERO  = 3'd0,
    REG_X_FULL  = 3'd1,
    REG_X_FS    = 3'd2,
    REG_Y_ZERO  = 3'd3,
    REG_Y_FULL  = 3'd4,
    REG_Y_FS    = 3'd5,
    REG_HOLDOFF = 3'd6
  } reg_idx_e;

  typedef enum logic [POS_W-1:0] {
    BYTE_GESTURE = 3'd0,
    BYTE_X_HI    = 3'd2,
    BYTE_X_LO    = 3'd3,
    BYTE_Y_HI    = 3'd4,
    BYTE_Y_LO    = 3'd5
  } byte_pos_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [COORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/trc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Requires num < den << COORD_W so the quotient fits COORD_W bits. Uses trc_pkg.
`default_nettype none
module trc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire trc_pkg::div_req_t  req_i,
  output trc_pkg::div_rsp_t       rsp_o
);

  logic [trc_pkg::COORD_W-1:0] rem_q, rem_d;
  logic [trc_pkg::COORD_W-1:0] low_q, low_d;
  logic [trc_pkg::COORD_W-1:0] den_q;
  logic [trc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [trc_pkg::COORD_W:0]   trial;
  logic [trc_pkg::COORD_W:0]   diff;
  logic                        qbit;

  always_comb begin
    trial = {rem_q, low_q[trc_pkg::COORD_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = rem_q;
    low_d = low_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.num[trc_pkg::NUM_W-1:trc_pkg::COORD_W];
      low_d = req_i.num[trc_pkg::COORD_W-1:0];
      cnt_d = trc_pkg::CNT_W'(trc_pkg::DIV_STEPS);
    end else if (cnt_q != '0) begin
      rem_d = qbit ? diff[trc_pkg::COORD_W-1:0] : trial[trc_pkg::COORD_W-1:0];
      low_d = {low_q[trc_pkg::COORD_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == trc_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule
`default_nettype wire

// File: rtl/core/touch_report_calibrator_unit.sv
// Touch report calibrator top level: report assembly, holdoff counter,
// per-axis sequencer around one multiplier and the shared trc_div divider.
// Depends on trc_pkg and trc_div.
//
//  channel  | dir | tdata                           | tuser
//  s_axis   | in  | [7:0] report_byte               | [0] op (0 tick, 1 byte)
//  m_axis   | out | [11:0] screen_x, [23:12] screen_y | [0] touch_seen, [1] fire
//  cfg      | in  | cfg_wdata_i, index cfg_idx_i    | write on cfg_we_i
//
// Ticks and non-final bytes are taken back to back; s_axis_tready stays high.
// Final byte: a non-touch goes from evaluation straight to done; a touch runs per axis
// one multiply, one range check, 12 divider steps and a done response on the shared
// divider; an axis settled by the range check skips the divider.
// s_axis_tready is low from the final byte until its result enters the output
// register; while m_axis still holds the previous result, that wait grows.
// Reset (async, active low) restores register defaults, clears the report state
// and presets the elapsed counter to 250.
`default_nettype none
module touch_report_calibrator_unit #(
  parameter int unsigned REPORT_BYTES = trc_pkg::REPORT_BYTES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // [7:0] report_byte
  input  wire logic                     s_axis_tuser,   // [0] op
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [11:0] screen_x, [23:12] screen_y
  output logic [1:0]                    m_axis_tuser,   // [0] touch_seen, [1] fire
  input  wire logic                     cfg_we_i,
  input  wire logic [trc_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [trc_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = trc_pkg::COORD_W;

  trc_pkg::seq_state_e state_q, state_d;
  logic axis_q, axis_d;

  logic [CW-1:0] x_zero_q, x_full_q, x_fs_q, y_zero_q, y_full_q, y_fs_q;
  logic [trc_pkg::HOLD_W-1:0] holdoff_q, elapsed_q;

  logic [trc_pkg::POS_W-1:0] pos_q;
  logic [7:0]    gest_q;
  logic [CW-1:0] raw_x_q, raw_y_q;

  logic signed [2*CW+1:0] prod_q;
  logic signed [CW:0]     den_q;
  logic [CW-1:0] sx_q, sy_q;
  logic          seen_q;

  logic          out_valid_q;
  logic [23:0]   out_data_q;
  logic [1:0]    out_user_q;

  logic in_xfer, last_byte, is_touch, out_free, fire;
  logic [CW-1:0] v_sel, a_sel, b_sel, f_sel;
  logic signed [CW:0]     diff_s, den_s;
  logic signed [2*CW+1:0] prod_s;
  logic [2*CW+1:0] num_abs;
  logic [CW:0]     den_abs;
  logic            ovf;
  logic            res_we;
  logic [CW-1:0]   res_val;

  trc_pkg::div_req_t div_req;
  trc_pkg::div_rsp_t div_rsp;

  trc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == trc_pkg::ST_IDLE);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign last_byte = (({1'b0, pos_q} + 4'd1) >= 4'(REPORT_BYTES));
  assign is_touch  = (gest_q == 8'd0) && ((raw_x_q != '0) || (raw_y_q != '0));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign fire      = seen_q && (elapsed_q > holdoff_q);

  always_comb begin
    v_sel  = axis_q ? raw_y_q  : raw_x_q;
    a_sel  = axis_q ? y_zero_q : x_zero_q;
    b_sel  = axis_q ? y_full_q : x_full_q;
    f_sel  = axis_q ? y_fs_q   : x_fs_q;
    diff_s = $signed({1'b0, v_sel}) - $signed({1'b0, a_sel});
    den_s  = $signed({1'b0, b_sel}) - $signed({1'b0, a_sel});
    prod_s = diff_s * $signed({1'b0, f_sel});
    num_abs = prod_q[2*CW+1] ? (2*CW+2)'(-prod_q) : (2*CW+2)'(prod_q);
    den_abs = den_q[CW] ? (CW+1)'(-den_q) : (CW+1)'(den_q);
    ovf     = (num_abs[2*CW-1:0] >= {den_abs[CW-1:0], {CW{1'b0}}});
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    res_we  = 1'b0;
    res_val = '0;
    div_req.start = 1'b0;
    div_req.num   = num_abs[2*CW-1:0];
    div_req.den   = den_abs[CW-1:0];
    case (state_q)
      trc_pkg::ST_IDLE: begin
        if (in_xfer && s_axis_tuser && last_byte) begin
          state_d = trc_pkg::ST_EVAL;
        end
      end
      trc_pkg::ST_EVAL: begin
        axis_d  = 1'b0;
        state_d = is_touch ? trc_pkg::ST_MUL : trc_pkg::ST_DONE;
      end
      trc_pkg::ST_MUL: begin
        state_d = trc_pkg::ST_CHK;
      end
      trc_pkg::ST_CHK: begin
        if ((den_q == '0) || (prod_q[2*CW+1] != den_q[CW])) begin
          res_we  = 1'b1;
          res_val = '0;
        end else if (ovf) begin
          res_we  = 1'b1;
          res_val = f_sel;
        end else begin
          div_req.start = 1'b1;
        end
        if (res_we) begin
          axis_d  = 1'b1;
          state_d = axis_q ? trc_pkg::ST_DONE : trc_pkg::ST_MUL;
        end else begin
          state_d = trc_pkg::ST_DIV;
        end
      end
      trc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_we  = 1'b1;
          res_val = (div_rsp.quot > f_sel) ? f_sel : div_rsp.quot;
          axis_d  = 1'b1;
          state_d = axis_q ? trc_pkg::ST_DONE : trc_pkg::ST_MUL;
        end
      end
      trc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = trc_pkg::ST_IDLE;
        end
      end
      default: state_d = trc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trc_pkg::ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_zero_q  <= trc_pkg::X_ZERO_RST;
      x_full_q  <= trc_pkg::X_FULL_RST;
      x_fs_q    <= trc_pkg::X_FS_RST;
      y_zero_q  <= trc_pkg::Y_ZERO_RST;
      y_full_q  <= trc_pkg::Y_FULL_RST;
      y_fs_q    <= trc_pkg::Y_FS_RST;
      holdoff_q <= trc_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trc_pkg::REG_X_ZERO:  x_zero_q  <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_X_FULL:  x_full_q  <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_X_FS:    x_fs_q    <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_Y_ZERO:  y_zero_q  <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_Y_FULL:  y_full_q  <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_Y_FS:    y_fs_q    <= cfg_wdata_i[CW-1:0];
        trc_pkg::REG_HOLDOFF: holdoff_q <= cfg_wdata_i[trc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // report assembly and holdoff counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      gest_q    <= '0;
      raw_x_q   <= '0;
      raw_y_q   <= '0;
      elapsed_q <= trc_pkg::ELAPSED_RST;
    end else begin
      if (in_xfer && !s_axis_tuser) begin
        if (elapsed_q != '1) begin
          elapsed_q <= elapsed_q + 1'b1;
        end
      end else if (in_xfer) begin
        case (pos_q)
          trc_pkg::BYTE_GESTURE: gest_q <= s_axis_tdata;
          trc_pkg::BYTE_X_HI: raw_x_q[CW-1:8] <= s_axis_tdata[3:0] & trc_pkg::NIBBLE_MASK;
          trc_pkg::BYTE_X_LO: raw_x_q[7:0]    <= s_axis_tdata;
          trc_pkg::BYTE_Y_HI: raw_y_q[CW-1:8] <= s_axis_tdata[3:0] & trc_pkg::NIBBLE_MASK;
          trc_pkg::BYTE_Y_LO: raw_y_q[7:0]    <= s_axis_tdata;
          default: ;
        endcase
        pos_q <= last_byte ? '0 : pos_q + 1'b1;
      end else if (state_q == trc_pkg::ST_DONE && out_free && fire) begin
        elapsed_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == trc_pkg::ST_MUL) begin
      prod_q <= prod_s;
      den_q  <= den_s;
    end
    if (state_q == trc_pkg::ST_EVAL) begin
      seen_q <= is_touch;
      sx_q   <= '0;
      sy_q   <= '0;
    end else if (res_we) begin
      if (axis_q) begin
        sy_q <= res_val;
      end else begin
        sx_q <= res_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == trc_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == trc_pkg::ST_DONE && out_free) begin
      out_data_q <= {sy_q, sx_q};
      out_user_q <= {fire, seen_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// File: rtl/core/trc_checker.sv
// Port-level checker for touch_report_calibrator_unit, attached by bind.
// Depends on the top level's port list only.
`default_nettype none
module trc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_fire_needs_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || !m_axis_tuser[1]))
    else $error("fire without touch_seen");

  a_no_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
    else $error("non-touch transfer carries coordinates");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled transfer changed");

endmodule

bind touch_report_calibrator_unit trc_checker u_trc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
